### sv/pkd_pkg.sv
`timescale 1ns / 1ps
package pkd_pkg;
  localparam int Slots = 64;
  localparam int PayloadBytes = 8;
  localparam int SlotW = $clog2(Slots);
  localparam int LinkW = SlotW + 1;
  localparam int CntW = $clog2(Slots + 1);
  localparam logic [LinkW-1:0] NulLink = LinkW'(Slots);

  typedef enum logic [2:0] {
    OpPushBack  = 3'd0,
    OpPushFront = 3'd1,
    OpPopFront  = 3'd2,
    OpRemove    = 3'd3,
    OpLookup    = 3'd4,
    OpPeek      = 3'd5,
    OpClear     = 3'd6,
    OpNone      = 3'd7
  } op_e;

  typedef enum logic [0:0] {
    RegCapacity  = 1'b0,
    RegInfoBytes = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    StIdle,
    StPushRd,
    StPushWr,
    StHeadRd,
    StSearch,
    StUnlink,
    StClearRd,
    StClearWr,
    StRefill,
    StDone
  } state_e;
endpackage

### sv/pooled_keyed_deque.sv
`timescale 1ns / 1ps
// Keyed deque over a pool of 64 slots with a FIFO of free slots.
// A command is taken at a clock edge where start is high and busy is low;
// its fields are operation_i, key_i, has_payload_i and payload_i.
// Every command yields one result, shown for one cycle with done_o high on
// ok_o, key_out_o, payload_out_o and count_o. The receiver cannot stall.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; they are taken only while no command is in progress.
// Push runs StPushRd then StPushWr; pop and peek read the head, lookup and
// remove walk the list one node per cycle through the slot memory read port,
// up to 64 nodes. Clear frees each entry in StClearRd and StClearWr.
// After reset, and after each capacity write, a refill pass in StRefill
// rewrites the free FIFO with ascending slot numbers; busy is high
// meanwhile. Slot payloads reset to zero only in the sense that a slot never
// written with a payload reads zero through a per-slot written bit.
module pooled_keyed_deque
  import pkd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [31:0] key_i,
  input  logic        has_payload_i,
  input  logic [63:0] payload_i,
  output logic        done_o,
  output logic        ok_o,
  output logic [31:0] key_out_o,
  output logic [63:0] payload_out_o,
  output logic [6:0]  count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  state_e state_q, state_d;
  logic [2:0]       op_q;
  logic [31:0]      key_q;
  logic             hasp_q;
  logic [63:0]      pay_q;
  logic [6:0]       cap_q;
  logic [3:0]       ib_q;
  logic [LinkW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]  lcnt_q, lcnt_d;
  logic [LinkW-1:0] cur_q, cur_d;
  logic [SlotW-1:0] fill_q, fill_d;
  logic [SlotW-1:0] steps_q, steps_d;
  logic [Slots-1:0] pvalid_q;
  logic             ok_q, ok_d;
  logic [31:0]      ko_q, ko_d;
  logic [63:0]      po_q, po_d;
  logic             done_q, done_d;
  logic             refill_pend_q, refill_pend_d;

  logic [SlotW-1:0] raddr;
  logic [SlotW-1:0] raddr_hold;
  logic [31:0]      rkey;
  logic [63:0]      rpay, rpay_eff, mask, wpay;
  logic [LinkW-1:0] rnext, rprev;
  logic wkey, wpay_en, wnext, wprev;
  logic [SlotW-1:0] waddr, wnext_addr, wprev_addr;
  logic [LinkW-1:0] wnext_data, wprev_data;
  logic [SlotW-1:0] fhead;
  logic [CntW-1:0]  fcnt, cap_eff;
  logic f_init, f_fill, f_pop, f_push;
  logic cfg_we;
  logic [3:0] nb;

  assign cfg_ready_o = (state_q == StIdle) && !refill_pend_q && !start;
  assign cfg_we = cfg_valid_i && cfg_ready_o;
  assign busy = (state_q != StIdle) || refill_pend_q;
  assign cap_eff = (cap_q > 7'(Slots)) ? CntW'(Slots) : cap_q[CntW-1:0];
  assign nb = (ib_q > 4'(PayloadBytes)) ? 4'(PayloadBytes) : ib_q;

  always_comb begin
    mask = '0;
    for (int b = 0; b < 8; b++) if (4'(b) < nb) mask[b*8 +: 8] = 8'hFF;
  end

  assign rpay_eff = pvalid_q[raddr_hold] ? rpay : 64'd0;
  always_ff @(posedge clk_i) raddr_hold <= raddr;

  pkd_store u_store (
    .clk_i, .raddr_i(raddr), .rkey_o(rkey), .rpay_o(rpay), .rnext_o(rnext),
    .rprev_o(rprev), .wkey_i(wkey), .waddr_i(waddr), .wkey_data_i(key_q),
    .wpay_data_i(wpay), .wpay_i(wpay_en), .wnext_i(wnext),
    .wnext_addr_i(wnext_addr), .wnext_data_i(wnext_data), .wprev_i(wprev),
    .wprev_addr_i(wprev_addr), .wprev_data_i(wprev_data)
  );

  pkd_free u_free (
    .clk_i, .rst_ni, .init_i(f_init), .init_cnt_i(cap_eff), .fill_i(f_fill),
    .fill_idx_i(fill_q), .pop_i(f_pop), .push_i(f_push),
    .push_slot_i(cur_q[SlotW-1:0]), .head_o(fhead), .count_o(fcnt)
  );

  assign wpay = (rpay_eff & ~mask) | (pay_q & mask);

  always_comb begin
    state_d = state_q;
    head_d = head_q;
    tail_d = tail_q;
    lcnt_d = lcnt_q;
    cur_d = cur_q;
    fill_d = fill_q;
    steps_d = steps_q;
    ok_d = ok_q;
    ko_d = ko_q;
    po_d = po_q;
    done_d = 1'b0;
    refill_pend_d = refill_pend_q;
    raddr = cur_q[SlotW-1:0];
    wkey = 1'b0;
    wpay_en = 1'b0;
    waddr = cur_q[SlotW-1:0];
    wnext = 1'b0;
    wnext_addr = '0;
    wnext_data = '0;
    wprev = 1'b0;
    wprev_addr = '0;
    wprev_data = '0;
    f_init = 1'b0;
    f_fill = 1'b0;
    f_pop = 1'b0;
    f_push = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (refill_pend_q) begin
          fill_d = '0;
          f_init = 1'b1;
          head_d = NulLink;
          tail_d = NulLink;
          lcnt_d = '0;
          refill_pend_d = 1'b0;
          state_d = StRefill;
        end else if (cfg_we) begin
          if (cfg_index_i == RegCapacity) refill_pend_d = 1'b1;
        end else if (start) begin
          ok_d = 1'b0;
          ko_d = '0;
          po_d = '0;
          steps_d = '0;
          unique case (op_e'(operation_i))
            OpPushBack, OpPushFront: begin
              if (fcnt == '0) state_d = StDone;
              else begin
                cur_d = {1'b0, fhead};
                f_pop = 1'b1;
                state_d = StPushRd;
              end
            end
            OpPopFront, OpPeek: begin
              cur_d = head_q;
              raddr = head_q[SlotW-1:0];
              state_d = (head_q == NulLink) ? StDone : StHeadRd;
            end
            OpRemove, OpLookup: begin
              cur_d = head_q;
              raddr = head_q[SlotW-1:0];
              state_d = (head_q == NulLink) ? StDone : StSearch;
            end
            OpClear: begin
              cur_d = head_q;
              raddr = head_q[SlotW-1:0];
              ok_d = 1'b1;
              state_d = (head_q == NulLink) ? StDone : StClearRd;
            end
            default: state_d = StDone;
          endcase
        end
      end
      StPushRd: begin
        wnext = 1'b1;
        wnext_addr = cur_q[SlotW-1:0];
        wprev = 1'b1;
        wprev_addr = cur_q[SlotW-1:0];
        if (op_q == OpPushBack) begin
          wnext_data = NulLink;
          wprev_data = tail_q;
        end else begin
          wnext_data = head_q;
          wprev_data = NulLink;
        end
        state_d = StPushWr;
      end
      StPushWr: begin
        wkey = 1'b1;
        wpay_en = hasp_q;
        if (op_q == OpPushBack) begin
          if (tail_q == NulLink) head_d = cur_q;
          else begin
            wnext = 1'b1;
            wnext_addr = tail_q[SlotW-1:0];
            wnext_data = cur_q;
          end
          tail_d = cur_q;
        end else begin
          if (head_q == NulLink) tail_d = cur_q;
          else begin
            wprev = 1'b1;
            wprev_addr = head_q[SlotW-1:0];
            wprev_data = cur_q;
          end
          head_d = cur_q;
        end
        lcnt_d = lcnt_q + 1'b1;
        ok_d = 1'b1;
        state_d = StDone;
      end
      StHeadRd: begin
        ok_d = 1'b1;
        ko_d = rkey;
        po_d = rpay_eff & mask;
        state_d = (op_q == OpPopFront) ? StUnlink : StDone;
      end
      StSearch: begin
        if (steps_q != '0 || raddr_hold == cur_q[SlotW-1:0]) begin
          if (rkey == key_q) begin
            ok_d = 1'b1;
            po_d = rpay_eff & mask;
            state_d = (op_q == OpRemove) ? StUnlink : StDone;
          end else if (rnext == NulLink || steps_q == SlotW'(Slots - 1)) begin
            state_d = StDone;
          end else begin
            cur_d = rnext;
            raddr = rnext[SlotW-1:0];
            steps_d = steps_q + 1'b1;
          end
        end else begin
          steps_d = steps_q;
        end
      end
      StUnlink: begin
        raddr = cur_q[SlotW-1:0];
        if (rprev == NulLink) head_d = rnext;
        else begin
          wnext = 1'b1;
          wnext_addr = rprev[SlotW-1:0];
          wnext_data = rnext;
        end
        if (rnext == NulLink) tail_d = rprev;
        else begin
          wprev = 1'b1;
          wprev_addr = rnext[SlotW-1:0];
          wprev_data = rprev;
        end
        if (lcnt_q != '0) lcnt_d = lcnt_q - 1'b1;
        f_push = 1'b1;
        state_d = StDone;
      end
      StClearRd: state_d = StClearWr;
      StClearWr: begin
        f_push = 1'b1;
        if (lcnt_q != '0) lcnt_d = lcnt_q - 1'b1;
        if (rnext == NulLink || steps_q == SlotW'(Slots - 1)) begin
          head_d = NulLink;
          tail_d = NulLink;
          lcnt_d = '0;
          state_d = StDone;
        end else begin
          cur_d = rnext;
          raddr = rnext[SlotW-1:0];
          steps_d = steps_q + 1'b1;
          state_d = StClearRd;
        end
      end
      StRefill: begin
        f_fill = 1'b1;
        fill_d = fill_q + 1'b1;
        if (fill_q == SlotW'(Slots - 1)) begin
          f_init = 1'b1;
          state_d = StIdle;
        end
      end
      StDone: begin
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q <= 7'd64;
      ib_q <= '0;
      head_q <= NulLink;
      tail_q <= NulLink;
      lcnt_q <= '0;
      pvalid_q <= '0;
      done_q <= 1'b0;
      refill_pend_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      tail_q <= tail_d;
      lcnt_q <= lcnt_d;
      done_q <= done_d;
      refill_pend_q <= refill_pend_d;
      if (cfg_we) begin
        if (cfg_index_i == RegCapacity) cap_q <= cfg_data_i;
        else ib_q <= cfg_data_i[3:0];
      end
      if (wpay_en) pvalid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    fill_q <= fill_d;
    steps_q <= steps_d;
    ok_q <= ok_d;
    ko_q <= ko_d;
    po_q <= po_d;
    if (state_q == StIdle && start && !busy) begin
      op_q <= operation_i;
      key_q <= key_i;
      hasp_q <= has_payload_i;
      pay_q <= payload_i;
    end
  end

  assign done_o = done_q;
  assign ok_o = ok_q;
  assign key_out_o = ko_q;
  assign payload_out_o = po_q;
  assign count_o = lcnt_q;
endmodule

### sv/pkd_store.sv
`timescale 1ns / 1ps
module pkd_store
  import pkd_pkg::*;
(
  input  logic                 clk_i,
  input  logic [SlotW-1:0]     raddr_i,
  output logic [31:0]          rkey_o,
  output logic [63:0]          rpay_o,
  output logic [LinkW-1:0]     rnext_o,
  output logic [LinkW-1:0]     rprev_o,
  input  logic                 wkey_i,
  input  logic [SlotW-1:0]     waddr_i,
  input  logic [31:0]          wkey_data_i,
  input  logic [63:0]          wpay_data_i,
  input  logic                 wpay_i,
  input  logic                 wnext_i,
  input  logic [SlotW-1:0]     wnext_addr_i,
  input  logic [LinkW-1:0]     wnext_data_i,
  input  logic                 wprev_i,
  input  logic [SlotW-1:0]     wprev_addr_i,
  input  logic [LinkW-1:0]     wprev_data_i
);
  logic [31:0]      key_mem  [Slots];
  logic [63:0]      pay_mem  [Slots];
  logic [LinkW-1:0] next_mem [Slots];
  logic [LinkW-1:0] prev_mem [Slots];

  always_ff @(posedge clk_i) begin
    if (wkey_i) key_mem[waddr_i] <= wkey_data_i;
    if (wpay_i) pay_mem[waddr_i] <= wpay_data_i;
    if (wnext_i) next_mem[wnext_addr_i] <= wnext_data_i;
    if (wprev_i) prev_mem[wprev_addr_i] <= wprev_data_i;
    rkey_o  <= key_mem[raddr_i];
    rpay_o  <= pay_mem[raddr_i];
    rnext_o <= next_mem[raddr_i];
    rprev_o <= prev_mem[raddr_i];
  end
endmodule

### sv/pkd_free.sv
`timescale 1ns / 1ps
module pkd_free
  import pkd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             init_i,
  input  logic [CntW-1:0]  init_cnt_i,
  input  logic             fill_i,
  input  logic [SlotW-1:0] fill_idx_i,
  input  logic             pop_i,
  input  logic             push_i,
  input  logic [SlotW-1:0] push_slot_i,
  output logic [SlotW-1:0] head_o,
  output logic [CntW-1:0]  count_o
);
  logic [SlotW-1:0] fifo_mem [Slots];
  logic [SlotW-1:0] rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SlotW-1:0] wr_pos;

  assign wr_pos = rd_q + cnt_q[SlotW-1:0];
  assign count_o = cnt_q;

  always_comb begin
    rd_d = rd_q;
    cnt_d = cnt_q;
    if (init_i) begin
      rd_d = '0;
      cnt_d = init_cnt_i;
    end else if (pop_i) begin
      rd_d = rd_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end else if (push_i && cnt_q < CntW'(Slots)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      cnt_q <= CntW'(Slots);
    end else begin
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_i) fifo_mem[fill_idx_i] <= fill_idx_i;
    else if (push_i && cnt_q < CntW'(Slots)) fifo_mem[wr_pos] <= push_slot_i;
    head_o <= fifo_mem[rd_d];
  end
endmodule
